[src/nhfr_pkg.sv]
// Shared types and constants for the NRZI HDLC frame receiver.
// Depends on nothing; imported by nhfr_core, nrzi_hdlc_frame_receiver and nhfr_checker.
`timescale 1ns / 1ps

package nhfr_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_ENABLE       = 2'd0;
    localparam logic [1:0] REG_SYNC_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_PREAMBLE_MIN = 2'd2;
    localparam logic [1:0] REG_MAX_BITS     = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CNT_W      = 11;

    // Configuration reset values
    localparam logic       RST_ENABLE       = 1'b1;
    localparam logic [7:0] RST_SYNC_TIMEOUT = 8'd16;
    localparam logic [7:0] RST_PREAMBLE_MIN = 8'd8;
    localparam logic [CNT_W-1:0] RST_MAX_BITS = 11'd1020;

    // Handler phases
    localparam logic [2:0] PH_OFF      = 3'd0;
    localparam logic [2:0] PH_RESET    = 3'd1;
    localparam logic [2:0] PH_WAIT     = 3'd2;
    localparam logic [2:0] PH_PREFETCH = 3'd3;
    localparam logic [2:0] PH_RECEIVE  = 3'd4;

    // Sync hunter phases
    localparam logic [1:0] SY_RESTART = 2'd0;
    localparam logic [1:0] SY_ZERO    = 2'd1;
    localparam logic [1:0] SY_ONE     = 2'd2;
    localparam logic [1:0] SY_FLAG    = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_STUFF  = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_CRC    = 2'd2;

    // Framing and CRC constants
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_GOOD  = 16'hF0B8;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [7:0]  HDLC_FLAG = 8'h7E;
    localparam logic [CNT_W-1:0] CNT_MAX       = 11'd2047;
    localparam logic [CNT_W-1:0] PREFETCH_BITS = 11'd8;
    localparam logic [7:0]  SYNC_MAX       = 8'd255;
    localparam logic [7:0]  SYNC_FLAG_ONE  = 8'd5;
    localparam logic [7:0]  SYNC_FLAG_ZERO = 8'd7;
    localparam logic [2:0]  ONES_LIMIT     = 3'd5;
    localparam logic [2:0]  BYTE_LAST_BIT  = 3'd7;

    // One result word
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       packet_start;
        logic       packet_commit;
        logic       error_valid;
        logic [1:0] error_code;
        logic       channel;
        logic       channel_hop;
    } t_result;

endpackage

[src/nhfr_core.sv]
// Per-bit receiver logic: NRZI decode, sync hunt, destuffing, CRC, framing.
// Holds the handler state and configuration. Depends on nhfr_pkg.
`timescale 1ns / 1ps

module nhfr_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_line_bit,
    input  logic                           i_cfg_we,
    input  logic [nhfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nhfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output nhfr_pkg::t_result              o_result
);
    import nhfr_pkg::*;

    // configuration
    logic [7:0]       r_sync_timeout;
    logic [7:0]       r_preamble_min;
    logic [CNT_W-1:0] r_max_bits;

    // handler state
    logic             r_prev_line, n_prev_line;
    logic [15:0]      r_window, n_window;
    logic [2:0]       r_phase, n_phase;
    logic [1:0]       r_sync, n_sync;
    logic [7:0]       r_sync_count, n_sync_count;
    logic [CNT_W-1:0] r_bit_count, n_bit_count;
    logic [2:0]       r_ones, n_ones;
    logic [7:0]       r_accum, n_accum;
    logic [15:0]      r_crc, n_crc;
    logic             r_channel, n_channel;

    logic             dec_bit;
    logic [15:0]      win_shift;
    logic [CNT_W-1:0] bc_inc;
    logic [7:0]       sc_dec;
    logic             alt;
    logic             rx_bit;
    logic [7:0]       acc_next;
    logic [15:0]      crc_next;
    t_result          res;

    // NRZI decode: no transition means 1
    assign dec_bit   = ~(r_prev_line ^ i_line_bit);
    assign win_shift = {dec_bit, r_window[15:1]};
    assign bc_inc    = (r_bit_count == CNT_MAX) ? r_bit_count : r_bit_count + 1'b1;
    assign sc_dec    = (r_sync_count != 8'd0) ? r_sync_count - 1'b1 : r_sync_count;
    assign alt       = (r_sync == SY_ZERO) ? dec_bit : ~dec_bit;
    assign rx_bit    = win_shift[7];
    assign acc_next  = {rx_bit, r_accum[7:1]};
    assign crc_next  = {1'b0, r_crc[15:1]} ^ ((rx_bit ^ r_crc[0]) ? CRC_POLY : 16'h0000);

    // next state and result for one line bit
    always_comb begin
        n_prev_line  = i_line_bit;
        n_window     = win_shift;
        n_phase      = r_phase;
        n_sync       = r_sync;
        n_sync_count = r_sync_count;
        n_bit_count  = r_bit_count;
        n_ones       = r_ones;
        n_accum      = r_accum;
        n_crc        = r_crc;
        n_channel    = r_channel;
        res          = '0;

        case (r_phase)
            PH_RESET: begin
                n_window         = win_shift & 16'h8000;
                n_bit_count      = '0;
                res.packet_start = 1'b1;
                res.byte_valid   = 1'b1;
                res.byte_value   = {7'd0, r_channel};
                n_phase          = PH_WAIT;
                n_sync           = SY_RESTART;
            end
            PH_WAIT: begin
                n_bit_count = bc_inc;
                case (r_sync)
                    SY_RESTART: begin
                        if (bc_inc > {3'd0, r_sync_timeout}) begin
                            n_phase = PH_RESET;
                        end else begin
                            n_sync_count = '0;
                            n_sync       = dec_bit ? SY_ONE : SY_ZERO;
                        end
                    end
                    SY_ZERO, SY_ONE: begin
                        if (alt) begin
                            n_sync_count = (r_sync_count == SYNC_MAX) ?
                                           r_sync_count : r_sync_count + 1'b1;
                            n_sync       = dec_bit ? SY_ONE : SY_ZERO;
                        end else if (r_sync_count > r_preamble_min) begin
                            n_sync_count = dec_bit ? SYNC_FLAG_ONE : SYNC_FLAG_ZERO;
                            n_sync       = SY_FLAG;
                        end else begin
                            n_sync = SY_RESTART;
                        end
                    end
                    default: begin
                        // counting down the rest of the start flag
                        n_sync_count = sc_dec;
                        if (sc_dec != 8'd0) begin
                            if (!dec_bit) n_sync = SY_RESTART;
                        end else if (!dec_bit) begin
                            n_bit_count = '0;
                            n_phase     = PH_PREFETCH;
                        end else begin
                            n_sync = SY_RESTART;
                        end
                    end
                endcase
            end
            PH_PREFETCH: begin
                n_bit_count = bc_inc;
                if (bc_inc == PREFETCH_BITS) begin
                    n_bit_count = '0;
                    n_ones      = '0;
                    n_accum     = '0;
                    n_crc       = CRC_INIT;
                    n_phase     = PH_RECEIVE;
                end
            end
            PH_RECEIVE: begin
                if (r_ones >= ONES_LIMIT) begin
                    // stuff bit position: must be a zero
                    if (rx_bit) begin
                        res.error_valid = 1'b1;
                        res.error_code  = ERR_STUFF;
                        n_phase         = PH_RESET;
                    end else begin
                        n_ones = '0;
                    end
                end else begin
                    n_ones      = rx_bit ? r_ones + 1'b1 : 3'd0;
                    n_crc       = crc_next;
                    n_accum     = acc_next;
                    n_bit_count = bc_inc;
                    if (r_bit_count[2:0] == BYTE_LAST_BIT) begin
                        res.byte_valid = 1'b1;
                        res.byte_value = acc_next;
                        n_accum        = '0;
                    end
                    if (win_shift[15:8] == HDLC_FLAG) begin
                        if (crc_next != CRC_GOOD) begin
                            res.error_valid = 1'b1;
                            res.error_code  = ERR_CRC;
                        end else begin
                            res.packet_commit = 1'b1;
                        end
                        n_phase = PH_RESET;
                    end else if (bc_inc > r_max_bits) begin
                        res.error_valid = 1'b1;
                        res.error_code  = ERR_LENGTH;
                        n_phase         = PH_RESET;
                    end
                end
            end
            default: begin
                // off: line still decoded and shifted
            end
        endcase

        // every fall back to the reset phase hops channel
        if (n_phase == PH_RESET) begin
            n_channel       = ~r_channel;
            res.channel_hop = 1'b1;
        end
        res.channel = n_channel;
    end

    assign o_result = res;

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_timeout <= RST_SYNC_TIMEOUT;
            r_preamble_min <= RST_PREAMBLE_MIN;
            r_max_bits     <= RST_MAX_BITS;
            r_prev_line    <= 1'b0;
            r_window       <= '0;
            r_phase        <= RST_ENABLE ? PH_RESET : PH_OFF;
            r_sync         <= SY_RESTART;
            r_sync_count   <= '0;
            r_bit_count    <= '0;
            r_ones         <= '0;
            r_accum        <= '0;
            r_crc          <= '0;
            r_channel      <= 1'b0;
        end else begin
            if (i_step) begin
                r_prev_line  <= n_prev_line;
                r_window     <= n_window;
                r_sync       <= n_sync;
                r_sync_count <= n_sync_count;
                r_bit_count  <= n_bit_count;
                r_ones       <= n_ones;
                r_accum      <= n_accum;
                r_crc        <= n_crc;
                r_channel    <= n_channel;
            end
            // enable write restarts or idles the handler
            if (i_cfg_we && (i_cfg_index == REG_ENABLE)) begin
                r_phase <= i_cfg_data[0] ? PH_RESET : PH_OFF;
            end else if (i_step) begin
                r_phase <= n_phase;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SYNC_TIMEOUT: r_sync_timeout <= i_cfg_data[7:0];
                    REG_PREAMBLE_MIN: r_preamble_min <= i_cfg_data[7:0];
                    REG_MAX_BITS:     r_max_bits <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[src/nrzi_hdlc_frame_receiver.sv]
// The result word of an accepted line bit is registered in the output register, or in the skid word on a stall.
// Throughput: one line bit per cycle while input ready is high; the per-bit update is one register stage.
// A skid word behind the output register takes one more line bit when the output stalls;
// input ready then drops until the stalled word leaves.
// Reset (synchronous, active low): handler in reset phase, channel 0, config defaults.
// Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module nrzi_hdlc_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_line_bit,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_byte_valid,
    output logic [7:0]                      o_byte_value,
    output logic                            o_packet_start,
    output logic                            o_packet_commit,
    output logic                            o_error_valid,
    output logic [1:0]                      o_error_code,
    output logic                            o_channel,
    output logic                            o_channel_hop,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nhfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nhfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import nhfr_pkg::*;

    t_result res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_fire;
    logic    out_fire;

    assign o_in_ready  = ~r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid & o_in_ready;
    assign out_fire    = r_out_valid & i_out_ready;

    nhfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_fire),
        .i_line_bit  (i_line_bit),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (res)
    );

    // output register with skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_out.byte_valid;
    assign o_byte_value    = r_out.byte_value;
    assign o_packet_start  = r_out.packet_start;
    assign o_packet_commit = r_out.packet_commit;
    assign o_error_valid   = r_out.error_valid;
    assign o_error_code    = r_out.error_code;
    assign o_channel       = r_out.channel;
    assign o_channel_hop   = r_out.channel_hop;

endmodule

[src/nhfr_checker.sv]
// Port-level checks for the NRZI HDLC frame receiver, bound to the top level.
// Depends on nhfr_pkg for the error codes.
`timescale 1ns / 1ps

module nhfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_byte_valid,
    input logic [7:0] o_byte_value,
    input logic       o_packet_start,
    input logic       o_packet_commit,
    input logic       o_error_valid,
    input logic [1:0] o_error_code,
    input logic       o_channel,
    input logic       o_channel_hop
);
    import nhfr_pkg::*;

    // a frame ends either good or bad, never both
    a_commit_xor_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_valid |-> !o_packet_commit
            && (o_error_code == ERR_STUFF || o_error_code == ERR_LENGTH
                || o_error_code == ERR_CRC))
        else $error("commit and error in one word, or bad error code");

    // a new packet opens with the channel tag, no hop, no error
    a_start_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_start |->
            o_byte_valid && !o_channel_hop && !o_error_valid && !o_packet_commit
            && o_byte_value == {7'd0, o_channel})
        else $error("packet start word malformed");

    // byte value reads zero without a byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_byte_value == 8'd0)
        else $error("byte value set without byte valid");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_byte_value) && $stable(o_channel)
            && $stable(o_error_valid))
        else $error("output word changed while stalled");

endmodule

bind nrzi_hdlc_frame_receiver nhfr_checker u_nhfr_checker (.*);
